// File: src/wads_pkg.sv
// ----------------------------------------------------------------------------
// Windowed ADC average scaler package
// Register indexes, field widths, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package wads_pkg;

	localparam int REG_IDX_BITS = 2;
	localparam int WIN_BITS     = 16;
	localparam int SCALE_BITS   = 24;
	localparam int OFS_BITS     = 16;
	localparam int MV_BITS      = 18;
	localparam int CNT_OUT_BITS = 16;
	localparam int OUT_BITS     = 40;
	localparam int FRAC_BITS    = 16;

	localparam logic [WIN_BITS-1:0]   WINDOW_RESET = 16'd500;
	localparam logic [SCALE_BITS-1:0] SCALE_RESET  = 24'd72090;
	localparam logic [OFS_BITS-1:0]   OFFSET_RESET = 16'd0;

	localparam logic [MV_BITS-1:0] MV_POS_LIMIT = 18'h1FFFF;
	localparam logic [MV_BITS-1:0] MV_NEG_LIMIT = 18'h30000;
	localparam logic [MV_BITS-1:0] MV_NEG_MAG   = 18'h10000;
	localparam logic [CNT_OUT_BITS-1:0] CNT_OUT_MAX = 16'hFFFF;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_WINDOW_MS   = 2'd0,
		REG_MV_PER_STEP = 2'd1,
		REG_OFFSET_MV   = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_OFS,
		ST_RND
	} state_t;

endpackage

// File: src/windowed_adc_average_scaler.sv
// ----------------------------------------------------------------------------
// Windowed ADC average scaler
// Accumulates ADC samples over a window of millisecond ticks and emits the
// rounded, calibrated window average in millivolts with the sample count.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  s_*      in         tuser: mode (1 = tick), tdata: sample
//  m_*      out        tdata: millivolts, sample_count
//  cfg_*    in         cfg_index: register, cfg_data: value
//
// A tick or a sample that does not close the window is handled in the idle state.
// A sample that closes the window starts a bit-serial shift-add multiply by the
// scale, then a restoring division by the sample count, one quotient bit per cycle,
// then the offset add and the rounding step.
// The input waits while that item is in progress; a held result stalls only
// the final rounding step. Reset loads the register defaults and clears the state.
module windowed_adc_average_scaler #(
	parameter int SAMPLE_BITS = 10,
	parameter int COUNT_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,

	input  logic s_tvalid,
	output logic s_tready,
	// Bits from the lowest up: sample.
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	// Bits from the lowest up: mode.
	input  logic s_tuser,

	output logic m_tvalid,
	input  logic m_tready,
	// Bits from the lowest up: millivolts, sample_count.
	output logic [wads_pkg::OUT_BITS-1:0] m_tdata,

	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [wads_pkg::REG_IDX_BITS-1:0] cfg_index,
	input  logic [wads_pkg::SCALE_BITS-1:0] cfg_data
);

	localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
	localparam int PROD_BITS = SUM_BITS + wads_pkg::SCALE_BITS;
	localparam int Y_BITS    = PROD_BITS + 2;
	localparam int STEP_BITS = $clog2(PROD_BITS);

	wads_pkg::state_t state_q, state_d;

	logic [wads_pkg::WIN_BITS-1:0]   window_q;
	logic [wads_pkg::SCALE_BITS-1:0] scale_q;
	logic [wads_pkg::OFS_BITS-1:0]   offset_q;

	logic [SUM_BITS-1:0]           sum_q;
	logic [COUNT_BITS-1:0]         cnt_q;
	logic [wads_pkg::WIN_BITS-1:0] elapsed_q;

	logic [STEP_BITS-1:0]            step_q;
	logic [PROD_BITS-1:0]            acc_q;
	logic [wads_pkg::SCALE_BITS-1:0] scl_q;
	logic [COUNT_BITS:0]             rem_q;
	logic [Y_BITS-1:0]               y_q;

	logic                          m_tvalid_q;
	logic [wads_pkg::OUT_BITS-1:0] m_tdata_q;

	logic                in_take;
	logic                is_tick;
	logic                emit;
	logic [SUM_BITS:0]   sum_add;
	logic [SUM_BITS-1:0] sum_new;
	logic [COUNT_BITS-1:0] cnt_new;
	logic                step_done;
	logic                out_free;

	logic [COUNT_BITS:0]   rem_sh;
	logic [COUNT_BITS+1:0] trial;

	logic [Y_BITS-1:0]        ofs_ext;
	logic [Y_BITS-1:0]        rnd_t;
	logic [Y_BITS-17:0]       mag;
	logic [wads_pkg::MV_BITS-1:0] mv;
	logic [wads_pkg::CNT_OUT_BITS-1:0] cnt_out;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == wads_pkg::ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign in_take   = s_tvalid && s_tready;
	assign is_tick   = s_tuser;
	assign emit      = in_take && !is_tick && (elapsed_q > window_q);
	assign step_done = (step_q == '0);
	assign out_free  = !m_tvalid_q || m_tready;

	assign sum_add = {1'b0, sum_q} + (SUM_BITS+1)'(s_tdata[SAMPLE_BITS-1:0]);
	assign sum_new = sum_add[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_add[SUM_BITS-1:0];
	assign cnt_new = (&cnt_q) ? cnt_q : cnt_q + 1'b1;

	assign rem_sh = {rem_q[COUNT_BITS-1:0], acc_q[PROD_BITS-1]};
	assign trial  = {1'b0, rem_sh} - {2'b00, cnt_q};

	assign ofs_ext = {{(Y_BITS-wads_pkg::OFS_BITS-wads_pkg::FRAC_BITS){offset_q[wads_pkg::OFS_BITS-1]}},
		offset_q, {wads_pkg::FRAC_BITS{1'b0}}};

	always_comb begin
		if (y_q[Y_BITS-1]) begin
			rnd_t = ~y_q + Y_BITS'(32769) - Y_BITS'(rem_q != '0);
		end else begin
			rnd_t = y_q + Y_BITS'(32768);
		end
		mag = rnd_t[Y_BITS-1:wads_pkg::FRAC_BITS];
		if (y_q[Y_BITS-1]) begin
			if (mag > (Y_BITS-16)'(wads_pkg::MV_NEG_MAG)) begin
				mv = wads_pkg::MV_NEG_LIMIT;
			end else begin
				mv = '0 - mag[wads_pkg::MV_BITS-1:0];
			end
		end else begin
			if (mag > (Y_BITS-16)'(wads_pkg::MV_POS_LIMIT)) begin
				mv = wads_pkg::MV_POS_LIMIT;
			end else begin
				mv = mag[wads_pkg::MV_BITS-1:0];
			end
		end
		if ((cnt_q >> wads_pkg::CNT_OUT_BITS) != '0) begin
			cnt_out = wads_pkg::CNT_OUT_MAX;
		end else begin
			cnt_out = wads_pkg::CNT_OUT_BITS'(cnt_q);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wads_pkg::ST_IDLE: begin
				if (emit) begin
					state_d = wads_pkg::ST_MUL;
				end
			end
			wads_pkg::ST_MUL: begin
				if (step_done) begin
					state_d = wads_pkg::ST_DIV;
				end
			end
			wads_pkg::ST_DIV: begin
				if (step_done) begin
					state_d = wads_pkg::ST_OFS;
				end
			end
			wads_pkg::ST_OFS: begin
				state_d = wads_pkg::ST_RND;
			end
			wads_pkg::ST_RND: begin
				if (out_free) begin
					state_d = wads_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wads_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wads_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= wads_pkg::WINDOW_RESET;
			scale_q  <= wads_pkg::SCALE_RESET;
			offset_q <= wads_pkg::OFFSET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wads_pkg::REG_WINDOW_MS:   window_q <= cfg_data[wads_pkg::WIN_BITS-1:0];
				wads_pkg::REG_MV_PER_STEP: scale_q  <= cfg_data;
				wads_pkg::REG_OFFSET_MV:   offset_q <= cfg_data[wads_pkg::OFS_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			cnt_q      <= '0;
			elapsed_q  <= '0;
			step_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == wads_pkg::ST_RND) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				wads_pkg::ST_IDLE: begin
					if (in_take) begin
						if (is_tick) begin
							if (!(&elapsed_q)) begin
								elapsed_q <= elapsed_q + 1'b1;
							end
						end else begin
							sum_q <= sum_new;
							cnt_q <= cnt_new;
							if (emit) begin
								elapsed_q <= '0;
								step_q    <= STEP_BITS'(wads_pkg::SCALE_BITS - 1);
							end
						end
					end
				end
				wads_pkg::ST_MUL: begin
					step_q <= step_done ? STEP_BITS'(PROD_BITS - 1) : step_q - 1'b1;
				end
				wads_pkg::ST_DIV: begin
					if (!step_done) begin
						step_q <= step_q - 1'b1;
					end
				end
				wads_pkg::ST_OFS: begin
				end
				wads_pkg::ST_RND: begin
					if (out_free) begin
						sum_q      <= '0;
						cnt_q      <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			wads_pkg::ST_IDLE: begin
				acc_q <= '0;
				rem_q <= '0;
				scl_q <= scale_q;
			end
			wads_pkg::ST_MUL: begin
				acc_q <= {acc_q[PROD_BITS-2:0], 1'b0}
					+ (scl_q[wads_pkg::SCALE_BITS-1] ? PROD_BITS'(sum_q) : '0);
				scl_q <= {scl_q[wads_pkg::SCALE_BITS-2:0], 1'b0};
			end
			wads_pkg::ST_DIV: begin
				if (trial[COUNT_BITS+1]) begin
					rem_q <= rem_sh;
					acc_q <= {acc_q[PROD_BITS-2:0], 1'b0};
				end else begin
					rem_q <= trial[COUNT_BITS:0];
					acc_q <= {acc_q[PROD_BITS-2:0], 1'b1};
				end
			end
			wads_pkg::ST_OFS: begin
				y_q <= {2'b00, acc_q} + ofs_ext;
			end
			wads_pkg::ST_RND: begin
				if (out_free) begin
					m_tdata_q <= {{(wads_pkg::OUT_BITS-wads_pkg::MV_BITS-wads_pkg::CNT_OUT_BITS){1'b0}},
						cnt_out, mv};
				end
			end
			default: begin
			end
		endcase
	end

	a_emit_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (state_q == wads_pkg::ST_MUL))
		else $error("A window close did not start the multiply.");

	a_busy_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != wads_pkg::ST_IDLE) |-> (cnt_q != '0))
		else $error("Division started with a zero sample count.");

	a_result_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> (m_tdata_q[wads_pkg::MV_BITS +: wads_pkg::CNT_OUT_BITS] != '0))
		else $error("A result carries a zero sample count.");

	a_result_clears_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wads_pkg::ST_RND) && out_free |=> (sum_q == '0) && (cnt_q == '0))
		else $error("Window state was not cleared after a result.");

endmodule

// File: tb/windowed_adc_average_scaler_tb.sv
// ----------------------------------------------------------------------------
// Windowed ADC average scaler testbench
// Streams ADC samples and millisecond ticks into the block through a bursty
// driver, predicts every closed window in exact integer arithmetic, and checks
// each reading against the oldest prediction while the output side stalls at
// random. Covers the register extremes, a zero window, rounding of halves, and
// saturation of the millivolt result.
// ----------------------------------------------------------------------------
module windowed_adc_average_scaler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_BITS = 10;
	localparam int COUNT_BITS = 16;
	localparam int SDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam longint SUM_FULL = (64'd1 << (SAMPLE_BITS + COUNT_BITS)) - 1;
	localparam longint COUNT_FULL = (64'd1 << COUNT_BITS) - 1;
	localparam longint ELAPSED_FULL = 65535;
	localparam longint MV_LOW = -65536;
	localparam longint MV_HIGH = 131071;
	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_TICK = 1'b1;
	localparam int SETTLE_CYCLES = 120;
	localparam longint CYCLE_LIMIT = 300000;

	typedef struct {
		logic mode;
		logic [SAMPLE_BITS-1:0] sample;
	} adc_item_t;

	typedef struct {
		logic [wads_pkg::MV_BITS-1:0] millivolts;
		logic [wads_pkg::CNT_OUT_BITS-1:0] count;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [SDATA_BITS-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [wads_pkg::OUT_BITS-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [wads_pkg::REG_IDX_BITS-1:0] cfg_index = '0;
	logic [wads_pkg::SCALE_BITS-1:0] cfg_data = '0;

	adc_item_t tx_items[$];
	reading_t pending_readings[$];

	longint acc_sum = 0;
	longint acc_count = 0;
	longint acc_elapsed = 0;
	longint cur_window = longint'(wads_pkg::WINDOW_RESET);
	longint cur_scale = longint'(wads_pkg::SCALE_RESET);
	longint cur_offset = longint'($signed(wads_pkg::OFFSET_RESET));

	bit in_accepted = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int rx_left = 0;
	int mismatch_count = 0;
	longint cycle_count = 0;

	windowed_adc_average_scaler #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COUNT_BITS(COUNT_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// The exact value is total / (65536 * count); round half away from zero.
	function automatic logic [wads_pkg::MV_BITS-1:0] scaled_millivolts(longint sum,
			longint cnt, longint scale, longint ofs);
		longint total;
		longint mag;
		longint q;
		total = sum * scale + ofs * 65536 * cnt;
		mag = (total < 0) ? -total : total;
		q = (mag + 32768 * cnt) / (65536 * cnt);
		if (total < 0) q = -q;
		if (q < MV_LOW) q = MV_LOW;
		if (q > MV_HIGH) q = MV_HIGH;
		return q[wads_pkg::MV_BITS-1:0];
	endfunction

	function automatic void track_item(adc_item_t it);
		reading_t r;
		if (it.mode == MODE_TICK) begin
			if (acc_elapsed < ELAPSED_FULL) acc_elapsed++;
		end else begin
			acc_sum = (SUM_FULL - acc_sum < it.sample) ? SUM_FULL : acc_sum + it.sample;
			if (acc_count < COUNT_FULL) acc_count++;
			if (acc_elapsed > cur_window) begin
				r.millivolts = scaled_millivolts(acc_sum, acc_count, cur_scale, cur_offset);
				r.count = (acc_count > 65535) ? wads_pkg::CNT_OUT_MAX
					: acc_count[wads_pkg::CNT_OUT_BITS-1:0];
				pending_readings.push_back(r);
				acc_sum = 0;
				acc_count = 0;
				acc_elapsed = 0;
			end
		end
	endfunction

	function automatic void queue_item(logic mode, int sample);
		tx_items.push_back(adc_item_t'{mode, SAMPLE_BITS'(sample)});
	endfunction

	function automatic void queue_ticks(int n);
		for (int i = 0; i < n; i++) queue_item(MODE_TICK, $urandom_range(0, 1023));
	endfunction

	task automatic report_mismatch(string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	task automatic write_reg(wads_pkg::reg_idx_t idx, logic [wads_pkg::SCALE_BITS-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			wads_pkg::REG_WINDOW_MS:
				cur_window = longint'(value[wads_pkg::WIN_BITS-1:0]);
			wads_pkg::REG_MV_PER_STEP: cur_scale = longint'(value);
			wads_pkg::REG_OFFSET_MV:
				cur_offset = longint'($signed(value[wads_pkg::OFS_BITS-1:0]));
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		do @(posedge clk);
		while (tx_items.size() != 0 || s_tvalid || pending_readings.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin
		adc_item_t next_item;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !in_accepted) begin
		end else if (gap_left > 0) begin
			s_tvalid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (tx_items.size() > 0) begin
			next_item = tx_items.pop_front();
			s_tvalid <= 1'b1;
			s_tuser <= next_item.mode;
			s_tdata <= SDATA_BITS'(next_item.sample);
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 20);
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	always @(posedge clk) begin
		in_accepted = arst_n && s_tvalid && s_tready;
		if (in_accepted) track_item(adc_item_t'{s_tuser, s_tdata[SAMPLE_BITS-1:0]});
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (rx_left == 0) begin
			m_tready <= ($urandom_range(0, 2) != 0);
			rx_left <= $urandom_range(1, 30);
		end else begin
			rx_left <= rx_left - 1;
		end
	end

	always @(posedge clk) begin
		reading_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else if (arst_n && m_tvalid && m_tready) begin
			if (pending_readings.size() == 0) begin
				report_mismatch($sformatf("unexpected reading %h", m_tdata));
			end else begin
				want = pending_readings.pop_front();
				if (m_tdata[wads_pkg::MV_BITS-1:0] !== want.millivolts)
					report_mismatch($sformatf("millivolts %0d, predicted %0d",
						$signed(m_tdata[wads_pkg::MV_BITS-1:0]), $signed(want.millivolts)));
				if (m_tdata[wads_pkg::MV_BITS +: wads_pkg::CNT_OUT_BITS] !== want.count)
					report_mismatch($sformatf("sample_count %0d, predicted %0d",
						m_tdata[wads_pkg::MV_BITS +: wads_pkg::CNT_OUT_BITS], want.count));
			end
		end
	end

	initial begin
		int win_val;
		int tick_pct;
		int pick;
		logic [wads_pkg::SCALE_BITS-1:0] scale_val;
		logic [wads_pkg::OFS_BITS-1:0] ofs_val;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Default scale and offset under a short window.
		write_reg(wads_pkg::REG_WINDOW_MS, 24'h000002);
		queue_item(MODE_SAMPLE, 0);
		queue_item(MODE_SAMPLE, 1023);
		queue_ticks(3);
		queue_item(MODE_SAMPLE, 512);
		settle();

		// Zero window, largest scale and offset: the result saturates high.
		write_reg(wads_pkg::REG_WINDOW_MS, 24'h000000);
		write_reg(wads_pkg::REG_MV_PER_STEP, 24'hFFFFFF);
		write_reg(wads_pkg::REG_OFFSET_MV, 24'h007FFF);
		queue_item(MODE_SAMPLE, 1023);
		queue_ticks(1);
		queue_item(MODE_SAMPLE, 5);
		queue_ticks(1);
		queue_item(MODE_SAMPLE, 0);
		settle();

		write_reg(wads_pkg::REG_WINDOW_MS, 24'hAB0001);
		write_reg(wads_pkg::REG_MV_PER_STEP, 24'h000000);
		write_reg(wads_pkg::REG_OFFSET_MV, 24'h5A8000);
		queue_ticks(2);
		queue_item(MODE_SAMPLE, 1023);
		settle();

		// Scale of 1.5 so that halves appear on both sides of zero.
		write_reg(wads_pkg::REG_WINDOW_MS, 24'h000002);
		write_reg(wads_pkg::REG_MV_PER_STEP, 24'h018000);
		write_reg(wads_pkg::REG_OFFSET_MV, 24'h00FFFF);
		queue_item(MODE_SAMPLE, 1);
		queue_item(MODE_SAMPLE, 0);
		queue_ticks(3);
		queue_item(MODE_SAMPLE, 0);
		settle();
		write_reg(wads_pkg::REG_OFFSET_MV, 24'h000000);
		queue_ticks(3);
		queue_item(MODE_SAMPLE, 1);
		settle();

		for (int p = 0; p < 8; p++) begin
			win_val = $urandom_range(0, 6);
			scale_val = wads_pkg::SCALE_BITS'($urandom);
			ofs_val = wads_pkg::OFS_BITS'($urandom);
			if (p == 2) scale_val = '0;
			if (p == 3) scale_val = '1;
			if (p == 4) ofs_val = 16'h8000;
			if (p == 5) ofs_val = 16'h7FFF;
			write_reg(wads_pkg::REG_WINDOW_MS, {8'($urandom), 16'(win_val)});
			write_reg(wads_pkg::REG_MV_PER_STEP, scale_val);
			write_reg(wads_pkg::REG_OFFSET_MV, {8'($urandom), ofs_val});
			tick_pct = $urandom_range(20, 60);
			for (int i = 0; i < 45; i++) begin
				if ($urandom_range(0, 99) < tick_pct) begin
					queue_ticks(1);
				end else begin
					pick = $urandom_range(0, 9);
					queue_item(MODE_SAMPLE,
						(pick == 0) ? 0 : (pick == 1) ? 1023 : $urandom_range(0, 1023));
				end
			end
			settle();
		end

		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
